/* src/arpc_pkg.sv */
// Shared request codes and field widths for the ARP address cache.
package arpc_pkg;

    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int SLOT_W = 3;

    typedef enum logic {
        REQ_LOOKUP = 1'b0,
        REQ_LEARN  = 1'b1
    } t_req_type;

endpackage

/* src/arpc_prio_enc.sv */
// Lowest-index priority encoder with one-hot and binary outputs.
module arpc_prio_enc #(
    parameter int N     = 8,
    parameter int IDX_W = 3
) (
    input  logic [N-1:0]     i_vec,
    output logic             o_any,
    output logic [N-1:0]     o_onehot,
    output logic [IDX_W-1:0] o_idx
);

    // Isolate the lowest set bit
    assign o_onehot = i_vec & (~i_vec + N'(1));
    assign o_any    = |i_vec;

    // Encode the one-hot vector; zero when nothing is set
    always_comb begin
        o_idx = '0;
        for (int i = 0; i < N; i++) begin
            if (o_onehot[i]) begin
                o_idx = o_idx | IDX_W'(i);
            end
        end
    end

endmodule

/* src/arp_address_cache_core.sv */
// Top level of the ARP address cache: fully associative IPv4-to-MAC table.
// Pipeline: input register, then result register.
// Throughput: one lookup or learn per cycle unless the output stalls; the compare against
//   all entries and the table write settle in the single stage between the two registers.
// Reset (synchronous, active low): all entry valid marks, the round-robin pointer and
//   both pipeline valid flags clear; entry contents are left as they are.
module arp_address_cache_core
    import arpc_pkg::*;
#(
    parameter int ENTRIES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic [IP_W-1:0]   i_ip_addr,
    input  logic [MAC_W-1:0]  i_new_mac,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_found,
    output logic [MAC_W-1:0]  o_result_mac,
    output logic [SLOT_W-1:0] o_slot
);

    localparam int IDX_W = $clog2(ENTRIES);

    // Table storage
    logic [ENTRIES-1:0]   r_entry_valid;
    logic [IP_W-1:0]      r_entry_ip  [ENTRIES];
    logic [MAC_W-1:0]     r_entry_mac [ENTRIES];
    logic [IDX_W-1:0]     r_replace_ptr;
    logic [IDX_W-1:0]     n_replace_ptr;

    // Input register
    logic                 r_in_valid;
    t_req_type            r_in_req;
    logic [IP_W-1:0]      r_in_ip;
    logic [MAC_W-1:0]     r_in_mac;

    // Result register
    logic                 r_out_valid;
    logic                 r_out_found;
    logic [MAC_W-1:0]     r_out_mac;
    logic [SLOT_W-1:0]    r_out_slot;

    logic                 advance;
    logic                 is_learn;
    logic                 do_write;
    logic [ENTRIES-1:0]   match_vec;
    logic                 hit_any;
    logic [ENTRIES-1:0]   hit_oh;
    logic [IDX_W-1:0]     hit_idx;
    logic                 free_any;
    logic [ENTRIES-1:0]   free_oh;
    logic [IDX_W-1:0]     free_idx;
    logic [ENTRIES-1:0]   write_oh;
    logic [IDX_W-1:0]     write_idx;
    logic [MAC_W-1:0]     hit_mac;
    logic                 n_found;
    logic [MAC_W-1:0]     n_mac;
    logic [SLOT_W-1:0]    n_slot;

    // Handshake: the result register frees up when empty or taken
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    assign is_learn = (r_in_req == REQ_LEARN);
    assign do_write = r_in_valid && advance && is_learn;

    // Compare the address against every entry
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i] = r_entry_valid[i] && (r_entry_ip[i] == r_in_ip);
        end
    end

    arpc_prio_enc #(
        .N     (ENTRIES),
        .IDX_W (IDX_W)
    ) u_hit_enc (
        .i_vec    (match_vec),
        .o_any    (hit_any),
        .o_onehot (hit_oh),
        .o_idx    (hit_idx)
    );

    arpc_prio_enc #(
        .N     (ENTRIES),
        .IDX_W (IDX_W)
    ) u_free_enc (
        .i_vec    (~r_entry_valid),
        .o_any    (free_any),
        .o_onehot (free_oh),
        .o_idx    (free_idx)
    );

    // Select the stored MAC of the matching entry
    always_comb begin
        hit_mac = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_mac = hit_mac | ({MAC_W{hit_oh[i]}} & r_entry_mac[i]);
        end
    end

    // Pick the learn target: matching entry, then lowest free one, then round robin
    always_comb begin
        n_replace_ptr = r_replace_ptr;
        if (hit_any) begin
            write_oh  = hit_oh;
            write_idx = hit_idx;
        end else if (free_any) begin
            write_oh  = free_oh;
            write_idx = free_idx;
        end else begin
            write_oh  = ENTRIES'(1) << r_replace_ptr;
            write_idx = r_replace_ptr;
            if (r_replace_ptr == IDX_W'(ENTRIES - 1)) begin
                n_replace_ptr = '0;
            end else begin
                n_replace_ptr = r_replace_ptr + IDX_W'(1);
            end
        end
    end

    // Form the result
    always_comb begin
        n_found = hit_any;
        if (is_learn) begin
            n_mac  = '0;
            n_slot = SLOT_W'(write_idx);
        end else begin
            n_mac  = hit_mac;
            n_slot = SLOT_W'(hit_idx);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_entry_valid <= '0;
            r_replace_ptr <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (do_write) begin
                r_entry_valid <= r_entry_valid | write_oh;
                r_replace_ptr <= n_replace_ptr;
            end
        end
    end

    // Payload registers: capture input, hold result
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_req <= t_req_type'(i_req_type);
            r_in_ip  <= i_ip_addr;
            r_in_mac <= i_new_mac;
        end
        if (advance && r_in_valid) begin
            r_out_found <= n_found;
            r_out_mac   <= n_mac;
            r_out_slot  <= n_slot;
        end
    end

    // Write the chosen entry on learn
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (do_write && write_oh[i]) begin
                r_entry_ip[i]  <= r_in_ip;
                r_entry_mac[i] <= r_in_mac;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_out_found;
    assign o_result_mac = r_out_mac;
    assign o_slot       = r_out_slot;

    // Learns keep each address in at most one valid entry
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> $onehot0(match_vec))
        else $error("address matches more than one valid entry");

    // A learn leaves its target entry valid
    a_learn_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_write |=> ((r_entry_valid & $past(write_oh)) == $past(write_oh)))
        else $error("learned entry not marked valid");

    // The round-robin pointer moves only on a learn into a full table
    a_ptr_moves_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(do_write && !hit_any && !free_any) |=> $stable(r_replace_ptr))
        else $error("replacement pointer moved without a full-table learn");

    // Valid marks stay clear right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_entry_valid == '0 && !r_out_valid && !r_in_valid))
        else $error("state not cleared by reset");

endmodule
